@@ hw/rtl/lsr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the light sample radiance pipeline.
// No dependencies.
package lsr_pkg;

  typedef enum logic [1:0] {
    LT_POINT  = 2'd0,
    LT_GRID   = 2'd1,
    LT_SPHERE = 2'd2,
    LT_DOME   = 2'd3
  } light_t;

  typedef enum logic [2:0] {
    REG_LAMP_KIND   = 3'd0,
    REG_TWO_SIDED   = 3'd1,
    REG_COLOR_RED   = 3'd2,
    REG_COLOR_GREEN = 3'd3,
    REG_COLOR_BLUE  = 3'd4,
    REG_INTENSITY   = 3'd5,
    REG_NUM_SAMPLES = 3'd6
  } cfg_idx_t;

  localparam logic [14:0] COS_ONE       = 15'd16384;
  localparam logic [15:0] RST_COLOR     = 16'd256;
  localparam logic [15:0] RST_INTENSITY = 16'd256;
  localparam logic [15:0] RST_COUNT     = 16'd16;

  localparam int SQ_STAGES = 25;
  localparam int CS_STAGES = 14;
  localparam int DV_STAGES = 32;

  typedef struct packed {
    logic [2:0][31:0] prod;
    logic [41:0]      dmag;
    logic             dneg;
    logic             sph;
  } side_t;

endpackage

@@ hw/rtl/light_sample_radiance.sv @@
`timescale 1ns / 1ps
// Light sample radiance: pipelined fixed-point shading of one light sample.
// Depends on lsr_pkg.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  request  | start / busy     | point_*, sample_*, normal_*, dome_*
//  result   | done (strobe)    | out_red, out_green, out_blue
//  config   | cfg_we           | cfg_index, cfg_data
//
// One request enters per cycle while busy is low; its result is on the outputs, one cycle
// wide on done. Four front stages, the sum register and 25-step square root, the limit
// check and 14-step cosine divider, and the scale register and 32-step divider by the
// sample count lie between the accepting edge and done.
// busy is high only right after rst (synchronous, active high); reset clears
// all valid bits. The receiver cannot stall, so nothing in the pipeline holds.
module light_sample_radiance (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [31:0] sample_x,
  input  logic signed [31:0] sample_y,
  input  logic signed [31:0] sample_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [15:0]        dome_red,
  input  logic [15:0]        dome_green,
  input  logic [15:0]        dome_blue,
  output logic [31:0]        out_red,
  output logic [31:0]        out_green,
  output logic [31:0]        out_blue
);

  lsr_pkg::light_t lamp_kind;
  logic            two_sided;
  logic [15:0]     color [3];
  logic [15:0]     intensity;
  logic [15:0]     num_samples;
  logic [15:0]     div_cnt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_kind   <= lsr_pkg::LT_POINT;
      two_sided   <= 1'b0;
      color[0]    <= lsr_pkg::RST_COLOR;
      color[1]    <= lsr_pkg::RST_COLOR;
      color[2]    <= lsr_pkg::RST_COLOR;
      intensity   <= lsr_pkg::RST_INTENSITY;
      num_samples <= lsr_pkg::RST_COUNT;
    end else if (cfg_we) begin
      unique case (lsr_pkg::cfg_idx_t'(cfg_index))
        lsr_pkg::REG_LAMP_KIND:   lamp_kind   <= lsr_pkg::light_t'(cfg_data[1:0]);
        lsr_pkg::REG_TWO_SIDED:   two_sided   <= cfg_data[0];
        lsr_pkg::REG_COLOR_RED:   color[0]    <= cfg_data;
        lsr_pkg::REG_COLOR_GREEN: color[1]    <= cfg_data;
        lsr_pkg::REG_COLOR_BLUE:  color[2]    <= cfg_data;
        lsr_pkg::REG_INTENSITY:   intensity   <= cfg_data;
        lsr_pkg::REG_NUM_SAMPLES: num_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  assign div_cnt = (lamp_kind == lsr_pkg::LT_POINT || num_samples == 16'd0)
                   ? 16'd1 : num_samples;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // stage 0: differences, normal, color select
  logic               v0;
  logic signed [32:0] d0 [3];
  logic signed [15:0] n0 [3];
  logic [15:0]        col0 [3];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= accept;
  end

  always_ff @(posedge clk) begin
    d0[0]   <= 33'(point_x) - 33'(sample_x);
    d0[1]   <= 33'(point_y) - 33'(sample_y);
    d0[2]   <= 33'(point_z) - 33'(sample_z);
    n0[0]   <= normal_x;
    n0[1]   <= normal_y;
    n0[2]   <= normal_z;
    col0[0] <= (lamp_kind == lsr_pkg::LT_DOME) ? dome_red   : color[0];
    col0[1] <= (lamp_kind == lsr_pkg::LT_DOME) ? dome_green : color[1];
    col0[2] <= (lamp_kind == lsr_pkg::LT_DOME) ? dome_blue  : color[2];
  end

  // stage 1: magnitudes, exact dot terms, intensity times color
  logic               v1;
  logic [31:0]        m1 [3];
  logic               neg1 [3];
  logic signed [15:0] n1 [3];
  logic signed [48:0] pd1 [3];
  logic [31:0]        prod1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg1[i]  <= d0[i][32];
      m1[i]    <= d0[i][32] ? 32'(-d0[i]) : 32'(d0[i]);
      n1[i]    <= n0[i];
      pd1[i]   <= d0[i] * n0[i];
      prod1[i] <= 32'(intensity) * 32'(col0[i]);
    end
  end

  // stage 2: sphere sign test, range reduction
  logic               v2;
  logic [23:0]        em2 [3];
  logic               en2 [3];
  logic signed [15:0] n2 [3];
  logic               sph2;
  logic [31:0]        prod2 [3];
  logic [31:0]        orv;
  logic [3:0]         shamt;
  logic signed [50:0] pds;

  always_comb begin
    orv   = m1[0] | m1[1] | m1[2];
    shamt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (orv[24 + k]) shamt = 4'(k + 1);
    end
    pds = 51'(pd1[0]) + 51'(pd1[1]) + 51'(pd1[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      em2[i]   <= 24'(m1[i] >> shamt);
      en2[i]   <= neg1[i];
      n2[i]    <= n1[i];
      prod2[i] <= prod1[i];
    end
    sph2 <= (pds > 51'sd0);
  end

  // stage 3: squares and reduced dot terms
  logic               v3;
  logic [47:0]        sq3 [3];
  logic signed [40:0] dp3 [3];
  logic               sph3;
  logic [31:0]        prod3 [3];
  logic signed [24:0] e25 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e25[i] = en2[i] ? -$signed({1'b0, em2[i]}) : $signed({1'b0, em2[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq3[i]   <= em2[i] * em2[i];
      dp3[i]   <= e25[i] * n2[i];
      prod3[i] <= prod2[i];
    end
    sph3 <= sph2;
  end

  // stage 4: sums feed the square root pipeline
  logic [49:0]          sq_x  [0:lsr_pkg::SQ_STAGES];
  logic [49:0]          sq_r  [0:lsr_pkg::SQ_STAGES];
  lsr_pkg::side_t       sq_sd [0:lsr_pkg::SQ_STAGES];
  logic [lsr_pkg::SQ_STAGES:0] sq_v;
  logic signed [42:0]   dot4;

  assign dot4 = 43'(dp3[0]) + 43'(dp3[1]) + 43'(dp3[2]);

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v3;
  end

  always_ff @(posedge clk) begin
    sq_x[0]          <= 50'(sq3[0]) + 50'(sq3[1]) + 50'(sq3[2]);
    sq_r[0]          <= 50'd0;
    sq_sd[0].prod[0] <= prod3[0];
    sq_sd[0].prod[1] <= prod3[1];
    sq_sd[0].prod[2] <= prod3[2];
    sq_sd[0].dneg    <= dot4[42];
    sq_sd[0].dmag    <= dot4[42] ? 42'(-dot4) : 42'(dot4);
    sq_sd[0].sph     <= sph3;
  end

  for (genvar k = 0; k < lsr_pkg::SQ_STAGES; k++) begin : g_sqrt
    localparam logic [49:0] B = 50'd1 << (48 - 2 * k);
    logic [49:0] trial;
    assign trial = sq_r[k] + B;

    always_ff @(posedge clk) begin
      if (rst) sq_v[k + 1] <= 1'b0;
      else     sq_v[k + 1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      sq_sd[k + 1] <= sq_sd[k];
      if (sq_x[k] >= trial) begin
        sq_x[k + 1] <= sq_x[k] - trial;
        sq_r[k + 1] <= (sq_r[k] >> 1) + B;
      end else begin
        sq_x[k + 1] <= sq_x[k];
        sq_r[k + 1] <= sq_r[k] >> 1;
      end
    end
  end

  // cosine divider: |dot| / len, limited to one
  logic [41:0]         cs_rem [0:lsr_pkg::CS_STAGES];
  logic [24:0]         cs_len [0:lsr_pkg::CS_STAGES];
  logic [14:0]         cs_q   [0:lsr_pkg::CS_STAGES];
  logic                cs_dn  [0:lsr_pkg::CS_STAGES];
  lsr_pkg::side_t      cs_sd  [0:lsr_pkg::CS_STAGES];
  logic [lsr_pkg::CS_STAGES:0] cs_v;
  logic [24:0]         root;
  logic                sat;

  assign root = sq_r[lsr_pkg::SQ_STAGES][24:0];
  assign sat  = sq_sd[lsr_pkg::SQ_STAGES].dmag >= 42'({root, 14'd0});

  always_ff @(posedge clk) begin
    if (rst) cs_v[0] <= 1'b0;
    else     cs_v[0] <= sq_v[lsr_pkg::SQ_STAGES];
  end

  always_ff @(posedge clk) begin
    cs_rem[0] <= sq_sd[lsr_pkg::SQ_STAGES].dmag;
    cs_len[0] <= root;
    cs_q[0]   <= sat ? lsr_pkg::COS_ONE : 15'd0;
    cs_dn[0]  <= sat;
    cs_sd[0]  <= sq_sd[lsr_pkg::SQ_STAGES];
  end

  for (genvar j = 0; j < lsr_pkg::CS_STAGES; j++) begin : g_cos
    localparam int SH = lsr_pkg::CS_STAGES - 1 - j;
    logic [41:0] sub;
    assign sub = 42'(cs_len[j]) << SH;

    always_ff @(posedge clk) begin
      if (rst) cs_v[j + 1] <= 1'b0;
      else     cs_v[j + 1] <= cs_v[j];
    end

    always_ff @(posedge clk) begin
      cs_len[j + 1] <= cs_len[j];
      cs_dn[j + 1]  <= cs_dn[j];
      cs_sd[j + 1]  <= cs_sd[j];
      if (!cs_dn[j] && cs_rem[j] >= sub) begin
        cs_rem[j + 1]    <= cs_rem[j] - sub;
        cs_q[j + 1]      <= cs_q[j] | (15'd1 << SH);
      end else begin
        cs_rem[j + 1]    <= cs_rem[j];
        cs_q[j + 1]      <= cs_q[j];
      end
    end
  end

  // scale stage: apply cosine (grid) or sphere test (sphere), else pass the product through
  logic [lsr_pkg::DV_STAGES:0] dv_v;
  logic [2:0][31:0]    dv_num [0:lsr_pkg::DV_STAGES];
  logic [2:0][15:0]    dv_rem [0:lsr_pkg::DV_STAGES];
  logic [14:0]         cu;
  logic [2:0][31:0]    xin;
  logic [46:0]         scaled [3];

  always_comb begin
    if (cs_len[lsr_pkg::CS_STAGES] == 25'd0) begin
      cu = 15'd0;
    end else if (!two_sided && cs_sd[lsr_pkg::CS_STAGES].dneg) begin
      cu = 15'd0;
    end else begin
      cu = cs_q[lsr_pkg::CS_STAGES];
    end
    for (int i = 0; i < 3; i++) begin
      scaled[i] = 47'(cs_sd[lsr_pkg::CS_STAGES].prod[i]) * 47'(cu);
      case (lamp_kind)
        lsr_pkg::LT_GRID:   xin[i] = 32'(scaled[i] >> 14);
        lsr_pkg::LT_SPHERE: xin[i] = cs_sd[lsr_pkg::CS_STAGES].sph
                                     ? cs_sd[lsr_pkg::CS_STAGES].prod[i] : 32'd0;
        default:            xin[i] = cs_sd[lsr_pkg::CS_STAGES].prod[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= cs_v[lsr_pkg::CS_STAGES];
  end

  always_ff @(posedge clk) begin
    dv_num[0] <= xin;
    dv_rem[0] <= '0;
  end

  // per-channel restoring divide by the sample count (one for point lights or a zero count)
  for (genvar k = 0; k < lsr_pkg::DV_STAGES; k++) begin : g_div
    logic [2:0][31:0] num_next;
    logic [2:0][15:0] rem_next;

    always_comb begin
      logic [16:0] tmp;
      logic        ge;
      for (int c = 0; c < 3; c++) begin
        tmp         = {dv_rem[k][c], dv_num[k][c][31]};
        ge          = tmp >= {1'b0, div_cnt};
        rem_next[c] = ge ? 16'(tmp - {1'b0, div_cnt}) : tmp[15:0];
        num_next[c] = {dv_num[k][c][30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[k + 1] <= 1'b0;
      else     dv_v[k + 1] <= dv_v[k];
    end

    always_ff @(posedge clk) begin
      dv_num[k + 1] <= num_next;
      dv_rem[k + 1] <= rem_next;
    end
  end

  assign done      = dv_v[lsr_pkg::DV_STAGES];
  assign out_red   = dv_num[lsr_pkg::DV_STAGES][0];
  assign out_green = dv_num[lsr_pkg::DV_STAGES][1];
  assign out_blue  = dv_num[lsr_pkg::DV_STAGES][2];

  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq_v[lsr_pkg::SQ_STAGES] |-> (sq_r[lsr_pkg::SQ_STAGES][49:25] == 25'd0))
    else $error("square root out of range");

  a_cos_limit: assert property (@(posedge clk) disable iff (rst)
    cs_v[lsr_pkg::CS_STAGES] |-> (cs_q[lsr_pkg::CS_STAGES] <= lsr_pkg::COS_ONE))
    else $error("cosine above one");

  a_sat_exact: assert property (@(posedge clk) disable iff (rst)
    (cs_v[lsr_pkg::CS_STAGES] && cs_dn[lsr_pkg::CS_STAGES])
      |-> (cs_q[lsr_pkg::CS_STAGES] == lsr_pkg::COS_ONE))
    else $error("limited cosine not one");

endmodule

@@ tb/sv/tb_light_sample_radiance.sv @@
`timescale 1ns / 1ps
// Testbench for light_sample_radiance: directed and random shading requests
// checked against a scoreboard that predicts each RGB contribution.
// Depends on lsr_pkg and light_sample_radiance.
module tb_light_sample_radiance;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [31:0] sx, sy, sz;
    logic signed [15:0] nx, ny, nz;
    logic [15:0] dr, dg, db;
  } shade_req_t;

  typedef struct packed {
    logic [31:0] r, g, b;
  } rgb_t;

  class radiance_scoreboard;
    lsr_pkg::light_t ltype;
    bit dsided;
    bit [15:0] color [3];
    bit [15:0] inten, count;
    rgb_t pending[$];
    int errors;

    function void reset_regs();
      ltype = lsr_pkg::LT_POINT;
      dsided = 0;
      foreach (color[i]) color[i] = lsr_pkg::RST_COLOR;
      inten = lsr_pkg::RST_INTENSITY;
      count = lsr_pkg::RST_COUNT;
    endfunction

    function void write_reg(logic [2:0] idx, bit [15:0] v);
      case (idx)
        lsr_pkg::REG_LAMP_KIND:   ltype = lsr_pkg::light_t'(v[1:0]);
        lsr_pkg::REG_TWO_SIDED:   dsided = v[0];
        lsr_pkg::REG_COLOR_RED:   color[0] = v;
        lsr_pkg::REG_COLOR_GREEN: color[1] = v;
        lsr_pkg::REG_COLOR_BLUE:  color[2] = v;
        lsr_pkg::REG_INTENSITY:   inten = v;
        lsr_pkg::REG_NUM_SAMPLES: count = v;
        default: ;
      endcase
    endfunction

    function longint unsigned root_floor(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function longint cosine(longint d [3], longint n [3]);
      longint unsigned mx, len2, len, q;
      longint e [3];
      longint dot;
      int s;
      mx = 0;
      s = 0;
      foreach (d[i]) if (mag(d[i]) > mx) mx = mag(d[i]);
      while ((mx >> s) >= (64'd1 << 24)) s++;
      foreach (d[i]) e[i] = d[i] < 0 ? -longint'(mag(d[i]) >> s) : longint'(mag(d[i]) >> s);
      len2 = 0;
      foreach (e[i]) len2 += longint'(e[i] * e[i]);
      len = root_floor(len2);
      if (len == 0) return 0;
      dot = e[0] * n[0] + e[1] * n[1] + e[2] * n[2];
      q = mag(dot) / len;
      if (q > lsr_pkg::COS_ONE) q = lsr_pkg::COS_ONE;
      return dot < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note(shade_req_t q);
      longint d [3], n [3];
      longint unsigned col [3], out [3];
      longint unsigned cnt, prod, cu;
      longint dot, c;
      rgb_t exp_rgb;
      d[0] = longint'(q.px) - longint'(q.sx);
      d[1] = longint'(q.py) - longint'(q.sy);
      d[2] = longint'(q.pz) - longint'(q.sz);
      n[0] = longint'(q.nx);
      n[1] = longint'(q.ny);
      n[2] = longint'(q.nz);
      cnt = count == 0 ? 1 : count;
      if (ltype == lsr_pkg::LT_DOME) begin
        col[0] = q.dr; col[1] = q.dg; col[2] = q.db;
      end else begin
        foreach (col[i]) col[i] = color[i];
      end
      dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      c = (ltype == lsr_pkg::LT_GRID) ? cosine(d, n) : 0;
      cu = dsided ? mag(c) : (c > 0 ? longint'(c) : 0);
      foreach (col[i]) begin
        prod = longint'(inten) * col[i];
        case (ltype)
          lsr_pkg::LT_POINT:  out[i] = prod;
          lsr_pkg::LT_DOME:   out[i] = prod / cnt;
          lsr_pkg::LT_SPHERE: out[i] = dot > 0 ? prod / cnt : 0;
          default:            out[i] = (prod * cu) / (cnt * lsr_pkg::COS_ONE);
        endcase
        if (out[i] > 64'hFFFF_FFFF) out[i] = 64'hFFFF_FFFF;
      end
      exp_rgb.r = out[0][31:0];
      exp_rgb.g = out[1][31:0];
      exp_rgb.b = out[2][31:0];
      pending.push_back(exp_rgb);
    endfunction

    function void check(rgb_t got);
      rgb_t want;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h %h %h", $time, got.r, got.g, got.b);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.r !== want.r) begin
        $display("%0t out_red expected %h actual %h", $time, want.r, got.r);
        errors++;
      end
      if (got.g !== want.g) begin
        $display("%0t out_green expected %h actual %h", $time, want.g, got.g);
        errors++;
      end
      if (got.b !== want.b) begin
        $display("%0t out_blue expected %h actual %h", $time, want.b, got.b);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  shade_req_t req = '0;
  logic [31:0] res_r, res_g, res_b;
  rgb_t res;
  radiance_scoreboard sb;
  int idle_cycles = 0;
  int idle_pct = 0;

  assign res = {res_r, res_g, res_b};

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  light_sample_radiance u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .point_x(req.px), .point_y(req.py), .point_z(req.pz),
    .sample_x(req.sx), .sample_y(req.sy), .sample_z(req.sz),
    .normal_x(req.nx), .normal_y(req.ny), .normal_z(req.nz),
    .dome_red(req.dr), .dome_green(req.dg), .dome_blue(req.db),
    .out_red(res_r), .out_green(res_g), .out_blue(res_b)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else                          idle_cycles <= idle_cycles + 1;
      if (start && !busy) sb.note(req);
      if (done) sb.check(res);
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send(shade_req_t q);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    req <= q;
    start <= 1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic set_light(lsr_pkg::light_t lt, bit ds, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b, logic [15:0] inten, logic [15:0] cnt);
    drain();
    write_reg(lsr_pkg::REG_LAMP_KIND, 16'(lt));
    write_reg(lsr_pkg::REG_TWO_SIDED, 16'(ds));
    write_reg(lsr_pkg::REG_COLOR_RED, r);
    write_reg(lsr_pkg::REG_COLOR_GREEN, g);
    write_reg(lsr_pkg::REG_COLOR_BLUE, b);
    write_reg(lsr_pkg::REG_INTENSITY, inten);
    write_reg(lsr_pkg::REG_NUM_SAMPLES, cnt);
    cfg_we <= 0;
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_normal();
    case ($urandom_range(7))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      default: return 16'($urandom_range(32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic shade_req_t random_req();
    shade_req_t q;
    int mode;
    mode = $urandom_range(9);
    q.px = 32'($urandom); q.py = 32'($urandom); q.pz = 32'($urandom);
    if (mode < 5) begin
      q.sx = q.px + 32'($signed($urandom_range(2097152)) - 1048576);
      q.sy = q.py + 32'($signed($urandom_range(2097152)) - 1048576);
      q.sz = q.pz + 32'($signed($urandom_range(2097152)) - 1048576);
    end else if (mode == 5) begin
      q.sx = q.px; q.sy = q.py; q.sz = q.pz;
    end else if (mode == 6) begin
      q.px = 32'h7FFF_FFFF; q.sx = 32'h8000_0000;
      q.sy = 32'($urandom); q.sz = 32'($urandom);
    end else begin
      q.sx = 32'($urandom); q.sy = 32'($urandom); q.sz = 32'($urandom);
    end
    q.nx = pick_normal(); q.ny = pick_normal(); q.nz = pick_normal();
    q.dr = pick16(); q.dg = pick16(); q.db = pick16();
    return q;
  endfunction

  function automatic shade_req_t directed_req(int k);
    shade_req_t q;
    q = '0;
    case (k)
      0: begin
        q.px = 32'sh0001_0000; q.nx = -16'sd16384;
        q.dr = 16'hFFFF; q.dg = 16'h0000; q.db = 16'h0100;
      end
      1: begin
        q.px = 32'sh7FFF_FFFF; q.py = 32'sh7FFF_FFFF; q.pz = 32'sh7FFF_FFFF;
        q.sx = 32'sh8000_0000; q.sy = 32'sh8000_0000; q.sz = 32'sh8000_0000;
        q.nx = 16'sd16384; q.ny = 16'sd16384; q.nz = 16'sd16384;
        q.dr = 16'hFFFF; q.dg = 16'hFFFF; q.db = 16'hFFFF;
      end
      2: begin
        q.px = 32'sh0012_3456; q.py = -32'sh0000_8000; q.pz = 32'sh0001_0000;
        q.sx = q.px; q.sy = q.py; q.sz = q.pz;
        q.nz = 16'sd16384; q.dr = 16'h1234;
      end
      3: begin
        q.pz = -32'sh0003_0000; q.nz = 16'sd16384;
        q.dg = 16'h8000;
      end
      default: begin
        q.px = 32'sh0000_0001; q.py = 32'sh0000_0001;
        q.nx = 16'sd16384; q.ny = 16'sd16384; q.nz = -16'sd16384;
        q.db = 16'h00FF;
      end
    endcase
    return q;
  endfunction

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int k = 0; k < 5; k++) send(directed_req(k));
    set_light(lsr_pkg::LT_GRID, 0, 16'hFFFF, 16'h0000, 16'h0100, 16'hFFFF, 16'd1);
    for (int k = 0; k < 5; k++) send(directed_req(k));
    set_light(lsr_pkg::LT_GRID, 1, 16'hFFFF, 16'h0001, 16'h0100, 16'hFFFF, 16'd0);
    for (int k = 0; k < 5; k++) send(directed_req(k));
    set_light(lsr_pkg::LT_SPHERE, 0, 16'hFFFF, 16'h8000, 16'h0100, 16'h0100, 16'hFFFF);
    for (int k = 0; k < 5; k++) send(directed_req(k));
    set_light(lsr_pkg::LT_DOME, 0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'd3);
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_we <= 0;
    for (int k = 0; k < 5; k++) send(directed_req(k));
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 66;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      set_light(lsr_pkg::light_t'(ph % 4), 1'($urandom), pick16(), pick16(), pick16(),
                pick16(), ph == 5 ? 16'd1 : (ph == 9 ? 16'hFFFF : pick16()));
      repeat (70) send(random_req());
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
